@@ rtl/skey_pkg.sv @@
// ----------------------------------------------------------------------------
// skey_pkg
// Shared widths, controller state codes and the command bundle that the
// sorter controller hands to the cell datapath.
// ----------------------------------------------------------------------------
package skey_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 32;
   localparam int KEY_WIDTH           = 32;
   localparam int TAG_WIDTH           = 16;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_cmd_type;

endpackage

@@ rtl/skey_cells.sv @@
// ----------------------------------------------------------------------------
// skey_cells
// Row of compare-and-shift cells. An insert places the new record behind all
// entries with a smaller or equal key; a shift moves the row one place toward
// cell 0 while the sorted run is read out.
// ----------------------------------------------------------------------------
module skey_cells #(
   parameter int MAX_ENTRIES = 32,
   parameter int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                                 clock,
   input  skey_pkg::cell_cmd_type               cmd,
   input  logic [COUNT_WIDTH-1:0]               fill_count,
   input  logic signed [skey_pkg::KEY_WIDTH-1:0] new_key,
   input  logic [skey_pkg::TAG_WIDTH-1:0]       new_tag,
   output logic signed [skey_pkg::KEY_WIDTH-1:0] head_key,
   output logic [skey_pkg::TAG_WIDTH-1:0]       head_tag
);
   import skey_pkg::*;

   logic signed [KEY_WIDTH-1:0] key_ff [MAX_ENTRIES];
   logic signed [KEY_WIDTH-1:0] key_in [MAX_ENTRIES];
   logic [TAG_WIDTH-1:0]        tag_ff [MAX_ENTRIES];
   logic [TAG_WIDTH-1:0]        tag_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]      greater;

   genvar i;
   generate
      for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
         logic below_fill;
         logic at_fill;
         logic prev_greater;

         assign below_fill = COUNT_WIDTH'(i) < fill_count;
         assign at_fill    = COUNT_WIDTH'(i) == fill_count;
         // Only occupied entries take part; the row is sorted, so this is a
         // contiguous run at the top of the occupied region.
         assign greater[i] = below_fill && (key_ff[i] > new_key);

         if (i == 0) begin : g_first
            assign prev_greater = 1'b0;
         end else begin : g_rest
            assign prev_greater = greater[i-1];
         end

         always_comb begin
            key_in[i] = key_ff[i];
            tag_in[i] = tag_ff[i];
            if (cmd.insert) begin
               if (prev_greater) begin
                  if (i > 0) begin
                     key_in[i] = key_ff[(i > 0) ? i - 1 : 0];
                     tag_in[i] = tag_ff[(i > 0) ? i - 1 : 0];
                  end
               end else if (greater[i] || at_fill) begin
                  key_in[i] = new_key;
                  tag_in[i] = new_tag;
               end
            end else if (cmd.shift_out) begin
               if (i < MAX_ENTRIES - 1) begin
                  key_in[i] = key_ff[(i < MAX_ENTRIES - 1) ? i + 1 : i];
                  tag_in[i] = tag_ff[(i < MAX_ENTRIES - 1) ? i + 1 : i];
               end
            end
         end

         always_ff @(posedge clock) begin
            key_ff[i] <= key_in[i];
            tag_ff[i] <= tag_in[i];
         end
      end
   endgenerate

   assign head_key = key_ff[0];
   assign head_tag = tag_ff[0];

endmodule

@@ rtl/skey_ctrl.sv @@
// ----------------------------------------------------------------------------
// skey_ctrl
// Controller: tracks the fill count and overflow flag, accepts records while
// filling, and steps the cell row through the read-out of a sorted run.
// ----------------------------------------------------------------------------
module skey_ctrl #(
   parameter int MAX_ENTRIES = 32,
   parameter int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_end_of_list,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_final_record,
   output logic                    rsp_records_dropped,
   output skey_pkg::cell_cmd_type  cmd,
   output logic [COUNT_WIDTH-1:0]  fill_count
);
   import skey_pkg::*;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] fill_ff, fill_in;
   logic                   overflow_ff, overflow_in;
   logic                   full;
   logic                   req_take;
   logic                   rsp_take;

   assign full     = fill_ff == COUNT_WIDTH'(MAX_ENTRIES);
   assign req_take = req_valid && (state_ff == ST_FILL);
   assign rsp_take = (state_ff == ST_DRAIN) && !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      overflow_in   = overflow_ff;
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            if (req_take) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  fill_in    = fill_ff + COUNT_WIDTH'(1);
               end
               if (req_end_of_list) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               cmd.shift_out = 1'b1;
               fill_in       = fill_ff - COUNT_WIDTH'(1);
               if (fill_ff == COUNT_WIDTH'(1)) begin
                  overflow_in = 1'b0;
                  state_in    = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         fill_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         overflow_ff <= overflow_in;
      end
   end

   assign req_stall           = state_ff != ST_FILL;
   assign rsp_valid           = state_ff == ST_DRAIN;
   assign rsp_final_record    = fill_ff == COUNT_WIDTH'(1);
   assign rsp_records_dropped = overflow_ff;
   assign fill_count          = fill_ff;

endmodule

@@ rtl/stable_key_sorter.sv @@
// ----------------------------------------------------------------------------
// stable_key_sorter
// Stable insertion sorter for lists of keyed records.
// ----------------------------------------------------------------------------
// Usage: records enter on the req_ channel, one per cycle while req_stall is
// low. Each record is inserted into a row of compare-and-shift cells in the
// cycle it is accepted, behind any stored record with an equal key, so a list
// streams in at one record per cycle. The record with req_end_of_list set is
// inserted like the rest and starts the read-out.
// During read-out req_stall is high and the rsp_ channel presents the stored
// records in ascending key order, one transaction per cycle while rsp_stall
// is low; the first result is valid in the cycle after the last record is
// accepted. Results leave through the single read port at cell 0 of the
// shifting row. rsp_final_record marks the last result, and
// rsp_records_dropped is high on every result of a list that had records
// arriving with all MAX_ENTRIES cells full; such records are discarded.
// While the receiver stalls, the result and the row hold. Reset empties the
// store and returns to accepting.
// ----------------------------------------------------------------------------
module stable_key_sorter #(
   parameter int MAX_ENTRIES = skey_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [skey_pkg::KEY_WIDTH-1:0] req_sort_key,
   input  logic [skey_pkg::TAG_WIDTH-1:0]        req_tag,
   input  logic                                  req_end_of_list,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [skey_pkg::KEY_WIDTH-1:0] rsp_sorted_key,
   output logic [skey_pkg::TAG_WIDTH-1:0]        rsp_sorted_tag,
   output logic                                  rsp_final_record,
   output logic                                  rsp_records_dropped
);
   import skey_pkg::*;

   localparam int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1);

   cell_cmd_type           cmd;
   logic [COUNT_WIDTH-1:0] fill_count;

   skey_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_end_of_list     (req_end_of_list),
      .req_stall           (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_final_record    (rsp_final_record),
      .rsp_records_dropped (rsp_records_dropped),
      .cmd                 (cmd),
      .fill_count          (fill_count)
   );

   skey_cells #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_cells (
      .clock      (clock),
      .cmd        (cmd),
      .fill_count (fill_count),
      .new_key    (req_sort_key),
      .new_tag    (req_tag),
      .head_key   (rsp_sorted_key),
      .head_tag   (rsp_sorted_tag)
   );

endmodule
